// ===== src/l4_protocol_bitvector_match_defines.svh =====
// Assertion macros for the l4bv RTL; the top-level file includes them.
`ifndef L4_PROTOCOL_BITVECTOR_MATCH_DEFINES_SVH
`define L4_PROTOCOL_BITVECTOR_MATCH_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define L4BV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define L4BV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/l4bv_pkg.sv =====
// Types and constants of the l4 protocol bit-vector match stage.
`timescale 1ns / 1ps

package l4bv_pkg;

  localparam int unsigned NUM_PROTOCOLS = 256;
  localparam int unsigned MAX_WORDS_DEF = 4;
  localparam int unsigned ProtoW        = 8;
  localparam int unsigned WidxW         = 2;
  localparam int unsigned VecW          = 64;
  localparam int unsigned LenW          = 16;
  localparam int unsigned CntW          = 64;
  localparam int unsigned ApbDataW      = 32;
  localparam int unsigned ApbAddrW      = 3;

  // Register index, taken from the word address bits of paddr.
  localparam logic REG_DEFAULT_ACCEPT = 1'b0;

  typedef enum logic [1:0] {
    MODE_PACKET = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_INVAL  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    VERDICT_CONTINUE = 2'd0,
    VERDICT_DROP     = 2'd1,
    VERDICT_ACCEPT   = 2'd2
  } verdict_e;

  // Request to the rule table: one write or one read per cycle.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ProtoW-1:0] protocol;
    logic [WidxW-1:0]  word_index;
  } mem_req_t;

endpackage

// ===== src/l4bv_in_if.sv =====
// Input word channel: valid/ready handshake with packet or table payload.
`timescale 1ns / 1ps

interface l4bv_in_if import l4bv_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [ProtoW-1:0] protocol;
  logic [WidxW-1:0]  word_index;
  logic [VecW-1:0]   bits;
  logic              last_word;
  logic [LenW-1:0]   packet_length;

  modport source (
    output valid, mode, protocol, word_index, bits, last_word, packet_length,
    input  ready
  );

  modport sink (
    input  valid, mode, protocol, word_index, bits, last_word, packet_length,
    output ready
  );
endinterface

// ===== src/l4bv_out_if.sv =====
// Result word channel: valid/ready handshake with the classified word.
`timescale 1ns / 1ps

interface l4bv_out_if import l4bv_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [VecW-1:0]  and_bits;
  logic [WidxW-1:0] out_word_index;
  logic             is_last;
  logic [1:0]       verdict;
  logic [CntW-1:0]  default_packets;
  logic [CntW-1:0]  default_bytes;

  modport source (
    output valid, and_bits, out_word_index, is_last, verdict, default_packets,
    default_bytes,
    input  ready
  );

  modport sink (
    input  valid, and_bits, out_word_index, is_last, verdict, default_packets,
    default_bytes,
    output ready
  );
endinterface

// ===== src/l4_protocol_bitvector_match.sv =====
// l4 protocol bit-vector classification stage (top level).
// Channels: in_i takes one word per handshake; mode selects a packet vector
// word, a rule table write or an entry invalidate. out_o returns one result
// word for each packet vector word; table writes and invalidates return
// nothing. The APB port holds default_accept at address 0 (pready is tied
// high; a write lands at the access cycle).
// A packet word accepted on in_i is held in the read stage, then moves to the result
// register when out_o has room. Throughput: one word per cycle while out_o does not
// stall, set by the single-port rule table read at the accept edge followed by one
// register stage before the result register.
// The verdict on the last word uses that word's match and the nonzero flag
// gathered over the packet; default_packets and default_bytes show the
// counters after that word's update.
// Reset clears all entry valid bits, the nonzero flag, both counters and
// default_accept; the table words stay undefined until written.
// When out_o stalls, the result register and the read stage hold, and
// in_i.ready drops only while both stages are full.
`timescale 1ns / 1ps
`include "l4_protocol_bitvector_match_defines.svh"

module l4_protocol_bitvector_match import l4bv_pkg::*; #(
  parameter int unsigned MaxWords = MAX_WORDS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  l4bv_in_if.sink             in_i,
  l4bv_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  // control and state
  logic [NUM_PROTOCOLS-1:0] entry_valid_q, entry_valid_d;
  logic                     dflt_accept_q;
  logic                     any_nz_q, any_nz_d;
  logic [CntW-1:0]          pkt_cnt_q, pkt_cnt_d;
  logic [CntW-1:0]          byte_cnt_q, byte_cnt_d;
  logic                     s1_valid_q, out_valid_q;

  // read stage payload
  logic                     s1_matched_q, s1_in_range_q, s1_last_q;
  logic [VecW-1:0]          s1_vec_q;
  logic [WidxW-1:0]         s1_widx_q;
  logic [LenW-1:0]          s1_plen_q;

  // result register
  logic [VecW-1:0]          and_bits_q, and_bits_d;
  logic [WidxW-1:0]         widx_q;
  logic                     last_q;
  verdict_e                 verdict_q, verdict_d;

  logic                     s2_adv, in_ready, in_acc;
  logic                     is_pkt, is_wr, is_inval, in_range;
  logic                     hit_proto, matched;
  logic                     nz_now, s2_default;
  logic [VecW-1:0]          rule_word;
  mem_req_t                 mem_req;
  logic                     cfg_wr;

  // input side: lookup and table update
  always_comb begin
    s2_adv    = s1_valid_q && (!out_valid_q || out_o.ready);
    in_ready  = !s1_valid_q || s2_adv;
    in_acc    = in_i.valid && in_ready;
    is_pkt    = in_i.mode == MODE_PACKET;
    is_wr     = in_i.mode == MODE_WRITE;
    is_inval  = in_i.mode == MODE_INVAL;
    in_range  = 32'(in_i.word_index) < 32'(MaxWords);
    hit_proto = entry_valid_q[in_i.protocol];
    matched   = hit_proto || entry_valid_q[0];

    // fall back to wildcard entry 0 when the protocol has no entry
    mem_req.wr_en      = in_acc && is_wr && in_range;
    mem_req.rd_en      = in_acc && is_pkt && in_range;
    mem_req.protocol   = (is_pkt && !hit_proto) ? '0 : in_i.protocol;
    mem_req.word_index = in_i.word_index;

    entry_valid_d = entry_valid_q;
    if (mem_req.wr_en) begin
      entry_valid_d[in_i.protocol] = 1'b1;
    end else if (in_acc && is_inval) begin
      entry_valid_d[in_i.protocol] = 1'b0;
    end
  end

  assign in_i.ready = in_ready;

  l4bv_rule_mem #(
    .MaxWords (MaxWords)
  ) u_rule_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .wr_data_i (in_i.bits),
    .rd_data_o (rule_word)
  );

  // result side: AND, nonzero tracking, verdict and counters
  always_comb begin
    and_bits_d = (s1_matched_q && s1_in_range_q) ? (s1_vec_q & rule_word) : s1_vec_q;
    nz_now     = any_nz_q || (and_bits_d != '0);
    s2_default = s1_last_q && (!s1_matched_q || !nz_now);
    verdict_d  = VERDICT_CONTINUE;
    any_nz_d   = any_nz_q;
    pkt_cnt_d  = pkt_cnt_q;
    byte_cnt_d = byte_cnt_q;
    if (s2_adv) begin
      any_nz_d = s1_last_q ? 1'b0 : nz_now;
      if (s2_default) begin
        verdict_d  = dflt_accept_q ? VERDICT_ACCEPT : VERDICT_DROP;
        pkt_cnt_d  = pkt_cnt_q + CntW'(1);
        byte_cnt_d = byte_cnt_q + CntW'(s1_plen_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      dflt_accept_q <= 1'b0;
      any_nz_q      <= 1'b0;
      pkt_cnt_q     <= '0;
      byte_cnt_q    <= '0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      entry_valid_q <= entry_valid_d;
      any_nz_q      <= any_nz_d;
      pkt_cnt_q     <= pkt_cnt_d;
      byte_cnt_q    <= byte_cnt_d;
      if (cfg_wr) begin
        dflt_accept_q <= pwdata[0];
      end
      if (in_ready) begin
        s1_valid_q <= in_acc && is_pkt;
      end
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_pkt) begin
      s1_matched_q  <= matched;
      s1_in_range_q <= in_range;
      s1_last_q     <= in_i.last_word;
      s1_vec_q      <= in_i.bits;
      s1_widx_q     <= in_i.word_index;
      s1_plen_q     <= in_i.packet_length;
    end
    if (s2_adv) begin
      and_bits_q <= and_bits_d;
      widx_q     <= s1_widx_q;
      last_q     <= s1_last_q;
      verdict_q  <= verdict_d;
    end
  end

  // counters only move when the result register loads, so they read through
  assign out_o.valid           = out_valid_q;
  assign out_o.and_bits        = and_bits_q;
  assign out_o.out_word_index  = widx_q;
  assign out_o.is_last         = last_q;
  assign out_o.verdict         = verdict_q;
  assign out_o.default_packets = pkt_cnt_q;
  assign out_o.default_bytes   = byte_cnt_q;

  // configuration port
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEFAULT_ACCEPT);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEFAULT_ACCEPT) ?
                  {{(ApbDataW-1){1'b0}}, dflt_accept_q} : '0;

  `L4BV_ASSERT_NOW(a_mid_word_continues, out_valid_q && !last_q,
                   verdict_q == VERDICT_CONTINUE, "verdict set on a non-final word")
  `L4BV_ASSERT_NEXT(a_default_counts, s2_adv && s2_default,
                    pkt_cnt_q == $past(pkt_cnt_q) + CntW'(1), "packet counter missed a default")
  `L4BV_ASSERT_NEXT(a_last_clears_nz, s2_adv && s1_last_q,
                    !any_nz_q, "nonzero flag survived the final word")
  `L4BV_ASSERT_NOW(a_stall_only_full, !in_ready,
                   s1_valid_q && out_valid_q && !out_o.ready, "input stalled with room")

endmodule

// ===== src/l4bv_rule_mem.sv =====
// Rule table memory: MaxWords 64-bit words per protocol, registered read.
`timescale 1ns / 1ps

module l4bv_rule_mem import l4bv_pkg::*; #(
  parameter int unsigned MaxWords = MAX_WORDS_DEF
) (
  input  logic            clk_i,
  input  mem_req_t        req_i,
  input  logic [VecW-1:0] wr_data_i,
  output logic [VecW-1:0] rd_data_o
);

  localparam int unsigned Depth = NUM_PROTOCOLS * MaxWords;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [VecW-1:0]  mem_q [Depth];
  logic [VecW-1:0]  rd_data_q;
  logic [AddrW-1:0] addr;

  // protocol * MaxWords + word index
  assign addr = AddrW'(req_i.protocol) * AddrW'(MaxWords) + AddrW'(req_i.word_index);

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[addr] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
